// ===== rtl/wpa_pkg.sv =====
// shared types and constants for the window peak autoscale block
package wpa_pkg;

    localparam int WINDOW   = 256;
    localparam int PTR_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int SCALE_W  = 16;

    localparam logic [SCALE_W-1:0] SCALE_LO   = SCALE_W'(100);
    localparam logic [SCALE_W-1:0] SCALE_MID  = SCALE_W'(250);
    localparam logic [SCALE_W-1:0] SCALE_HI   = SCALE_W'(500);
    localparam logic [SCALE_W-1:0] SCALE_STEP = SCALE_W'(1000);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MAG_W-1:0]           mag_t;
    typedef logic [SCALE_W-1:0]         scale_t;
    typedef logic [PTR_W-1:0]           ptr_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mm_ctrl_t;

    typedef struct packed {
        mag_t peak;
        mag_t minpos;
        logic has_pos;
    } mm_stat_t;

endpackage

// ===== rtl/wpa_if.sv =====
// channel interfaces for samples and results
interface wpa_sample_if;
    import wpa_pkg::*;

    logic    valid;
    logic    ready;
    sample_t current_sample;
    logic    voltage_present;

    modport source (output valid, output current_sample, output voltage_present, input ready);
    modport sink (input valid, input current_sample, input voltage_present, output ready);
endinterface

interface wpa_result_if;
    import wpa_pkg::*;

    logic   valid;
    logic   ready;
    logic   accepted;
    mag_t   window_max;
    mag_t   window_min;
    scale_t full_scale;

    modport source (
        output valid, output accepted, output window_max, output window_min,
        output full_scale, input ready
    );
    modport sink (
        input valid, input accepted, input window_max, input window_min,
        input full_scale, output ready
    );
endinterface

// ===== rtl/wpa_ram.sv =====
// generic simple dual-port ram with registered read
module wpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wpa_minmax.sv =====
// running peak and smallest positive value over the scanned window
module wpa_minmax (
    input  logic              clk,
    input  logic              rst_n,
    input  wpa_pkg::mm_ctrl_t ctrl,
    input  wpa_pkg::sample_t  sample,
    output wpa_pkg::mm_stat_t stat
);
    import wpa_pkg::*;

    mag_t peak_reg, peak_next;
    mag_t minpos_reg, minpos_next;
    logic has_pos_reg, has_pos_next;
    logic positive;
    mag_t mag;

    assign positive = (sample > sample_t'(0));
    assign mag      = sample[MAG_W-1:0];

    always_comb
    begin
        peak_next    = peak_reg;
        minpos_next  = minpos_reg;
        has_pos_next = has_pos_reg;
        if (ctrl.clear)
        begin
            peak_next    = '0;
            minpos_next  = '0;
            has_pos_next = 1'b0;
        end
        else if (ctrl.en && positive)
        begin
            if (mag > peak_reg)
            begin
                peak_next = mag;
            end
            if (!has_pos_reg || (mag < minpos_reg))
            begin
                minpos_next = mag;
            end
            has_pos_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= '0;
            minpos_reg  <= '0;
            has_pos_reg <= 1'b0;
        end
        else
        begin
            peak_reg    <= peak_next;
            minpos_reg  <= minpos_next;
            has_pos_reg <= has_pos_next;
        end
    end

    assign stat.peak    = peak_reg;
    assign stat.minpos  = minpos_reg;
    assign stat.has_pos = has_pos_reg;

endmodule

// ===== rtl/wpa_scale.sv =====
// full-scale ceiling by threshold or repeated addition of one thousand
module wpa_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  wpa_pkg::mag_t   peak,
    output logic            done,
    output wpa_pkg::scale_t scale
);
    import wpa_pkg::*;

    scale_t acc_reg, acc_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    scale_t peak_ext;

    assign peak_ext = SCALE_W'(peak);

    always_comb
    begin
        acc_next  = acc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (peak_ext < SCALE_LO)
            begin
                acc_next  = SCALE_LO;
                done_next = 1'b1;
            end
            else if (peak_ext < SCALE_MID)
            begin
                acc_next  = SCALE_MID;
                done_next = 1'b1;
            end
            else if (peak_ext < SCALE_HI)
            begin
                acc_next  = SCALE_HI;
                done_next = 1'b1;
            end
            else
            begin
                acc_next  = SCALE_STEP;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (acc_reg > peak_ext)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + SCALE_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= SCALE_LO;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done  = done_reg;
    assign scale = acc_reg;

endmodule

// ===== rtl/window_peak_autoscale.sv =====
// top level: sliding-window peak, positive minimum and autoscale tracker
// A sample with voltage_present low is answered in the next cycle with the held
// results and accepted low. A live sample is written into the window memory and
// the whole window is rescanned through its single read port, one entry per
// cycle; when the peak is 500 or more the ceiling is found by adding 1000 once
// per cycle. Window entries not yet filled are left out of the scan, as
// tracked by a fill count, so no clearing pass follows reset. Samples are taken
// only while the block is idle; a finished result waits in the output register.
module window_peak_autoscale (
    input  logic         clk,
    input  logic         rst_n,
    wpa_sample_if.sink   samples,
    wpa_result_if.source results
);
    import wpa_pkg::*;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SCAN       = 3'd1;
    localparam logic [2:0] ST_TAIL       = 3'd2;
    localparam logic [2:0] ST_SCALE_GO   = 3'd3;
    localparam logic [2:0] ST_SCALE_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE       = 3'd5;

    logic [2:0] state_reg, state_next;
    ptr_t       cnt_reg, cnt_next;
    ptr_t       ptr_reg, ptr_next;
    cnt_t       fill_reg, fill_next;
    logic       rd_vld_reg, rd_vld_next;
    logic       rd_live_reg, rd_live_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_acc_reg, out_acc_next;
    mag_t       out_max_reg, out_max_next;
    mag_t       out_min_reg, out_min_next;
    scale_t     out_scale_reg, out_scale_next;

    logic       in_acc;
    logic       live_acc;
    logic       slot_free;
    sample_t    rd_data;
    mm_ctrl_t   mm_ctrl;
    mm_stat_t   mm_stat;
    logic       scale_start;
    logic       scale_done;
    scale_t     scale_val;

    assign slot_free     = !out_valid_reg || results.ready;
    assign samples.ready = (state_reg == ST_IDLE) && slot_free;
    assign in_acc        = samples.valid && samples.ready;
    assign live_acc      = in_acc && samples.voltage_present;

    wpa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (live_acc),
        .wr_addr (ptr_reg),
        .wr_data (samples.current_sample),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    assign mm_ctrl.clear = live_acc;
    assign mm_ctrl.en    = rd_vld_reg && rd_live_reg;

    wpa_minmax u_minmax (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mm_ctrl),
        .sample (rd_data),
        .stat   (mm_stat)
    );

    wpa_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .peak  (mm_stat.peak),
        .done  (scale_done),
        .scale (scale_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        rd_vld_next    = 1'b0;
        rd_live_next   = 1'b0;
        scale_start    = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        out_acc_next   = out_acc_reg;
        out_max_next   = out_max_reg;
        out_min_next   = out_min_reg;
        out_scale_next = out_scale_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (live_acc)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                    if (fill_reg != CNT_W'(WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next  = 1'b1;
                rd_live_next = (CNT_W'(cnt_reg) < fill_reg);
                if (cnt_reg == PTR_W'(WINDOW - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_SCALE_GO;
            end
            ST_SCALE_GO:
            begin
                scale_start = 1'b1;
                state_next  = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT:
            begin
                if (scale_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b1;
                    out_max_next   = mm_stat.peak;
                    out_min_next   = mm_stat.has_pos ? mm_stat.minpos : mm_stat.peak;
                    out_scale_next = scale_val;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_max_reg   <= '0;
            out_min_reg   <= '0;
            out_scale_reg <= SCALE_LO;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            rd_live_reg   <= rd_live_next;
            out_valid_reg <= out_valid_next;
            out_acc_reg   <= out_acc_next;
            out_max_reg   <= out_max_next;
            out_min_reg   <= out_min_next;
            out_scale_reg <= out_scale_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.accepted   = out_acc_reg;
    assign results.window_max = out_max_reg;
    assign results.window_min = out_min_reg;
    assign results.full_scale = out_scale_reg;

endmodule

// ===== tb/tb.sv =====
// testbench for window_peak_autoscale: directed and random samples against a predictor
`timescale 1ns / 1ps

module tb;
    import wpa_pkg::*;

    localparam int HOLD_OFF_CYCLES = 700;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 300;
    localparam int PRESSURE_AT     = 60;

    typedef struct packed {
        logic   accepted;
        mag_t   window_max;
        mag_t   window_min;
        scale_t full_scale;
    } peak_result_t;

    class peak_scoreboard;
        sample_t      window_samples[WINDOW];
        ptr_t         oldest;
        peak_result_t held;
        peak_result_t pending_results[$];
        int           mismatches;
        int           results_checked;
        int           band_hits[4];

        function new();
            foreach (window_samples[i])
                window_samples[i] = '0;
            oldest          = '0;
            held            = '{1'b0, mag_t'(0), mag_t'(0), SCALE_LO};
            mismatches      = 0;
            results_checked = 0;
            foreach (band_hits[i])
                band_hits[i] = 0;
        endfunction

        function scale_t ceiling_for(mag_t peak);
            if (peak >= SCALE_HI)
                return scale_t'((int'(peak) / int'(SCALE_STEP) + 1) * int'(SCALE_STEP));
            if (peak >= SCALE_MID)
                return SCALE_HI;
            if (peak >= SCALE_LO)
                return SCALE_MID;
            return SCALE_LO;
        endfunction

        function void note_sample(sample_t s, logic live);
            int           peak;
            int           low;
            peak_result_t expected;
            if (live)
            begin
                window_samples[oldest] = s;
                oldest = (oldest == ptr_t'(WINDOW - 1)) ? '0 : oldest + 1'b1;
                peak = 0;
                foreach (window_samples[i])
                    if (int'(window_samples[i]) > peak)
                        peak = int'(window_samples[i]);
                low = peak;
                foreach (window_samples[i])
                    if (int'(window_samples[i]) > 0 && int'(window_samples[i]) < low)
                        low = int'(window_samples[i]);
                held.window_max = mag_t'(peak);
                held.window_min = mag_t'(low);
                held.full_scale = ceiling_for(held.window_max);
            end
            expected          = held;
            expected.accepted = live;
            pending_results.insert(pending_results.size(), expected);
        endfunction

        function void check_result(peak_result_t got);
            peak_result_t expected;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result acc=%0b max=%0d min=%0d scale=%0d",
                             got.accepted, got.window_max, got.window_min, got.full_scale);
                return;
            end
            expected = pending_results[0];
            pending_results.delete(0);
            results_checked++;
            if (expected.full_scale == SCALE_LO)
                band_hits[0]++;
            else if (expected.full_scale == SCALE_MID)
                band_hits[1]++;
            else if (expected.full_scale == SCALE_HI)
                band_hits[2]++;
            else
                band_hits[3]++;
            if (got != expected)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d: expected acc=%0b max=%0d min=%0d scale=%0d",
                             results_checked, expected.accepted, expected.window_max,
                             expected.window_min, expected.full_scale);
                    $display("    got acc=%0b max=%0d min=%0d scale=%0d",
                             got.accepted, got.window_max, got.window_min,
                             got.full_scale);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wpa_sample_if sample_ch ();
    wpa_result_if result_ch ();

    window_peak_autoscale DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    peak_scoreboard sb;
    int sent_count     = 0;
    int live_count     = 0;
    int ignored_count  = 0;
    int received_count = 0;
    int idle_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic sample_t random_sample();
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2: return sample_t'($urandom_range(1, 1200));
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       base = int'(SCALE_LO);
                    1:       base = int'(SCALE_MID);
                    2:       base = int'(SCALE_HI);
                    default: base = int'(SCALE_STEP);
                endcase
                return sample_t'(base - int'($urandom_range(0, 1)));
            end
            4:
            begin
                base = int'($urandom_range(1, 32)) * int'(SCALE_STEP);
                return sample_t'(base - int'($urandom_range(0, 1)));
            end
            5: return sample_t'($urandom);
            6: return sample_t'(-int'($urandom_range(1, 32768)));
            7: return sample_t'($urandom_range(1200, 32767));
            8: return sample_t'(0);
            default: return sample_t'($urandom_range(1, 99));
        endcase
    endfunction

    function automatic sample_t non_positive_sample();
        case ($urandom_range(0, 7))
            0, 1: return sample_t'(0);
            2:    return sample_t'(-1);
            3:    return sample_t'(-32768);
            default: return sample_t'(-int'($urandom_range(1, 32768)));
        endcase
    endfunction

    task automatic send_sample(input sample_t s, input logic live);
        int gap;
        gap = ((sent_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.current_sample  <= s;
        sample_ch.voltage_present <= live;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(s, live);
        sent_count++;
        if (live)
            live_count++;
        else
            ignored_count++;
        @(negedge clk);
    endtask

    task automatic send_random(input int live_target, input bit non_positive);
        int      done;
        logic    live;
        sample_t s;
        done = 0;
        while (done < live_target)
        begin
            live = ($urandom_range(0, 99) >= (non_positive ? 5 : 15));
            s = (non_positive && live) ? non_positive_sample() : random_sample();
            send_sample(s, live);
            if (live)
                done++;
        end
    endtask

    initial
    begin : result_sink
        int           gap;
        peak_result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            if (received_count == PRESSURE_AT)
                gap = HOLD_OFF_CYCLES;
            else
                gap = ((received_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got = '{result_ch.accepted, result_ch.window_max, result_ch.window_min,
                    result_ch.full_scale};
            sb.check_result(got);
            received_count++;
            @(negedge clk);
        end
    end

    initial
    begin
        sb = new();
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.current_sample  = '0;
        sample_ch.voltage_present = 1'b0;
        result_ch.ready           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ignored before anything lands, then the ceiling thresholds in turn
        send_sample(sample_t'(1234), 1'b0);
        send_sample(sample_t'(-5), 1'b1);
        send_sample(sample_t'(0), 1'b1);
        send_sample(sample_t'(1), 1'b1);
        send_sample(sample_t'(99), 1'b1);
        send_sample(sample_t'(100), 1'b1);
        send_sample(sample_t'(249), 1'b1);
        send_sample(sample_t'(250), 1'b1);
        send_sample(sample_t'(499), 1'b1);
        send_sample(sample_t'(500), 1'b1);
        send_sample(sample_t'(999), 1'b1);
        send_sample(sample_t'(1000), 1'b1);
        send_sample(sample_t'(-32768), 1'b1);
        send_sample(sample_t'(32767), 1'b1);
        send_sample(sample_t'(32767), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(32000), 1'b1);
        send_sample(sample_t'(-32768), 1'b0);
        send_sample(sample_t'(2), 1'b1);
        send_sample(sample_t'(16384), 1'b1);
        send_sample(sample_t'(-1), 1'b1);

        // general mix, then a flush with no positive samples, then the mix again
        send_random(120, 1'b0);
        send_random(270, 1'b1);
        send_random(90, 1'b0);
        sample_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d samples (%0d live, %0d ignored), %0d results checked",
                 sent_count, live_count, ignored_count, sb.results_checked);
        $display("ceilings seen: %0d at 100, %0d at 250, %0d at 500, %0d in thousands",
                 sb.band_hits[0], sb.band_hits[1], sb.band_hits[2], sb.band_hits[3]);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
